@@ hw/rtl/plis_pkg.sv @@
// Shared constants, codes and types for the positional list insert/search unit.
package plis_pkg;

  localparam int CAPACITY = 16;
  localparam int ENTRY_W  = 32;
  localparam int POS_W    = 8;
  localparam int WHERE_W  = 5;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd5;
  localparam logic [STAT_W-1:0] STAT_ELEMENT  = 3'd6;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic take_new;   // store the incoming value
    logic take_left;  // store the left neighbour's entry (shift back)
    logic load;       // copy entry into the read-out stage
    logic adv;        // read-out stage takes right neighbour's stage
  } cell_ctrl_t;

  // Read-out stage travelling towards the head
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [ENTRY_W-1:0] data;
  } scan_t;

endpackage

@@ hw/rtl/plis_cell.sv @@
// One list cell: stored entry, key compare and one read-out stage.
module plis_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  plis_pkg::cell_ctrl_t          ctrl,
  input  logic                          occupied,
  input  logic [plis_pkg::ENTRY_W-1:0]  new_value,
  input  logic [plis_pkg::ENTRY_W-1:0]  key,
  input  logic [plis_pkg::ENTRY_W-1:0]  left_entry,
  input  plis_pkg::scan_t               right_scan,
  output logic [plis_pkg::ENTRY_W-1:0]  entry,
  output plis_pkg::scan_t               scan,
  output logic                          hit
);

  logic [plis_pkg::ENTRY_W-1:0] entry_r;
  logic                         scan_valid_r;
  logic                         scan_hit_r;
  logic [plis_pkg::ENTRY_W-1:0] scan_data_r;

  assign hit   = occupied && (entry_r == key);
  assign entry = entry_r;
  assign scan  = '{valid: scan_valid_r, hit: scan_hit_r, data: scan_data_r};

  always_ff @(posedge clk) begin
    if (ctrl.take_new) begin
      entry_r <= new_value;
    end else if (ctrl.take_left) begin
      entry_r <= left_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_valid_r <= 1'b0;
      scan_hit_r   <= 1'b0;
    end else if (ctrl.load) begin
      scan_valid_r <= occupied;
      scan_hit_r   <= hit;
    end else if (ctrl.adv) begin
      scan_valid_r <= right_scan.valid;
      scan_hit_r   <= right_scan.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      scan_data_r <= entry_r;
    end else if (ctrl.adv) begin
      scan_data_r <= right_scan.data;
    end
  end

endmodule

@@ hw/rtl/positional_list_insert_search_unit.sv @@
// Top level: sequencer, output register and the row of list cells.
//
// Bounded ordered list of signed 32-bit values held in a row of cells.
// Input channel (in_*): one word per request; in_tuser carries the request
// kind (insert, search, dump), in_tdata the value and the 1-based position.
// Result channel (out_*): out_tuser carries the status, out_tdata the
// position and element, out_tlast marks the final word of a request.
// Insert shifts every cell from the target position back by one, all in
// the same cycle. Search and dump copy the row into the read-out stages,
// which then move one cell towards the head per cycle while not stalled;
// the head stage is reported. Hit flags ride along: the final match is known.
// A request is taken in S_IDLE and decided in S_EXEC; insert and
// single-word answers go to the output register from S_EXEC. Search
// and dump words come from S_SCAN as the read-out chain steps towards
// the head; a dump ends at the last entry, a search at its last match.
// One request is in flight; receiver stalls hold the sequencer in
// S_EXEC or S_SCAN.
// Reset (rst_n low, synchronous) empties the list and drops any result.
// Receiver stalls hold read-out at a word due; the last result holds in
// the output register while the next request is already accepted.
module positional_list_insert_search_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [39:32] position
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] where, [36:5] element, [39:37] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last
);

  localparam int CAP = plis_pkg::CAPACITY;
  localparam int EW  = plis_pkg::ENTRY_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [plis_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [plis_pkg::IDX_W-1:0] scan_idx_r, scan_idx_nxt;

  // Captured request
  logic [plis_pkg::REQ_W-1:0] req_r;
  logic [EW-1:0]              val_r;
  logic [plis_pkg::POS_W-1:0] pos_r;

  // Output register
  logic                          out_valid_r;
  logic [plis_pkg::STAT_W-1:0]   out_status_r;
  logic [plis_pkg::WHERE_W-1:0]  out_where_r;
  logic [EW-1:0]                 out_elem_r;
  logic                          out_last_r;

  logic                          emit;
  logic [plis_pkg::STAT_W-1:0]   em_status;
  logic [plis_pkg::WHERE_W-1:0]  em_where;
  logic [EW-1:0]                 em_elem;
  logic                          em_last;
  logic                          out_free;

  // Cell row
  plis_pkg::cell_ctrl_t cell_ctrl [CAP];
  plis_pkg::scan_t      cell_scan [CAP];
  logic [EW-1:0]        cell_entry [CAP];
  logic [CAP-1:0]       cell_hit;
  logic [CAP-1:0]       occupied;
  logic [CAP-1:0]       scan_valid_v;
  logic [CAP-1:0]       scan_hit_v;

  logic                       do_ins;
  logic                       load;
  logic                       adv;
  logic [plis_pkg::IDX_W-1:0] ins_idx;
  logic [plis_pkg::CMP_W-1:0] pos_ext;
  logic [plis_pkg::CMP_W-1:0] cnt_ext;
  logic [plis_pkg::CMP_W-1:0] pos_m1;
  logic                       list_empty;
  logic                       list_full;
  logic                       pos_bad;
  logic                       any_hit;
  logic                       more_valid;
  logic                       more_hit;
  logic [plis_pkg::CNT_W-1:0] head_pos;

  assign in_tready  = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_tready;

  assign list_empty = (count_r == '0);
  assign list_full  = (count_r == plis_pkg::CNT_W'(CAP));
  assign pos_ext    = plis_pkg::CMP_W'(pos_r);
  assign cnt_ext    = plis_pkg::CMP_W'(count_r);
  assign pos_m1     = pos_ext - plis_pkg::CMP_W'(1);
  assign pos_bad    = (pos_r == '0) || (pos_ext > cnt_ext + plis_pkg::CMP_W'(1));
  // An empty list always takes the value at the head
  assign ins_idx    = list_empty ? '0 : pos_m1[plis_pkg::IDX_W-1:0];

  assign any_hit    = |cell_hit;
  assign more_valid = |scan_valid_v[CAP-1:1];
  assign more_hit   = |scan_hit_v[CAP-1:1];
  assign head_pos   = plis_pkg::CNT_W'(scan_idx_r) + plis_pkg::CNT_W'(1);

  genvar k;
  generate
    for (k = 0; k < CAP; k++) begin : g_cell
      assign occupied[k]           = (plis_pkg::CNT_W'(k) < count_r);
      assign cell_ctrl[k].take_new = do_ins && (ins_idx == plis_pkg::IDX_W'(k));
      assign cell_ctrl[k].take_left = do_ins && (plis_pkg::IDX_W'(k) > ins_idx);
      assign cell_ctrl[k].load     = load;
      assign cell_ctrl[k].adv      = adv;
      assign scan_valid_v[k]       = cell_scan[k].valid;
      assign scan_hit_v[k]         = cell_scan[k].hit;

      plis_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cell_ctrl[k]),
        .occupied   (occupied[k]),
        .new_value  (val_r),
        .key        (val_r),
        .left_entry ((k == 0) ? val_r : cell_entry[(k == 0) ? 0 : k - 1]),
        .right_scan ((k == CAP - 1) ? plis_pkg::scan_t'('0)
                                    : cell_scan[(k == CAP - 1) ? k : k + 1]),
        .entry      (cell_entry[k]),
        .scan       (cell_scan[k]),
        .hit        (cell_hit[k])
      );
    end
  endgenerate

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    emit         = 1'b0;
    em_status    = plis_pkg::STAT_EMPTY;
    em_where     = '0;
    em_elem      = '0;
    em_last      = 1'b1;
    do_ins       = 1'b0;
    load         = 1'b0;
    adv          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_r) inside
          plis_pkg::REQ_INSERT: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (list_full) begin
                em_status = plis_pkg::STAT_FULL;
              end else if (list_empty) begin
                do_ins    = 1'b1;
                count_nxt = plis_pkg::CNT_W'(1);
                em_status = plis_pkg::STAT_INSERTED;
                em_where  = plis_pkg::WHERE_W'(1);
                em_elem   = val_r;
              end else if (pos_bad) begin
                em_status = plis_pkg::STAT_INVALID;
              end else begin
                do_ins    = 1'b1;
                count_nxt = count_r + plis_pkg::CNT_W'(1);
                em_status = plis_pkg::STAT_INSERTED;
                em_where  = plis_pkg::WHERE_W'(pos_r);
                em_elem   = val_r;
              end
            end
          end
          plis_pkg::REQ_SEARCH, plis_pkg::REQ_DUMP: begin
            if (list_empty || (req_r == plis_pkg::REQ_SEARCH && !any_hit)) begin
              if (out_free) begin
                emit      = 1'b1;
                em_status = list_empty ? plis_pkg::STAT_EMPTY : plis_pkg::STAT_NOTFOUND;
                state_nxt = S_IDLE;
              end
            end else begin
              load         = 1'b1;
              scan_idx_nxt = '0;
              state_nxt    = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (req_r == plis_pkg::REQ_DUMP || cell_scan[0].hit) begin
          if (out_free) begin
            emit         = 1'b1;
            adv          = 1'b1;
            scan_idx_nxt = scan_idx_r + plis_pkg::IDX_W'(1);
            em_where     = plis_pkg::WHERE_W'(head_pos);
            em_elem      = cell_scan[0].data;
            if (req_r == plis_pkg::REQ_DUMP) begin
              em_status = plis_pkg::STAT_ELEMENT;
              em_last   = !more_valid;
            end else begin
              em_status = plis_pkg::STAT_FOUND;
              em_last   = !more_hit;
            end
            if (em_last) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          // entry without a match: skip it
          adv          = 1'b1;
          scan_idx_nxt = scan_idx_r + plis_pkg::IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= emit || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= in_tuser;
      val_r <= in_tdata[EW-1:0];
      pos_r <= in_tdata[EW+plis_pkg::POS_W-1:EW];
    end
    if (emit) begin
      out_status_r <= em_status;
      out_where_r  <= em_where;
      out_elem_r   <= em_elem;
      out_last_r   <= em_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_elem_r, out_where_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= plis_pkg::CNT_W'(CAP))
    else $error("list count above capacity");

  a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> cell_scan[0].valid)
    else $error("read-out ran past the last entry");

  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> $stable(count_r))
    else $error("count changed outside an insert");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result word overwritten before it was taken");
`endif

endmodule
